FILE: design/salc_pkg.sv
// shared constants, types and helpers for the set-associative lru cache tag model
package salc_pkg;

	// default sizing of the tag store
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 8;

	// fixed field widths
	localparam int ADDR_W     = 64;
	localparam int TAG_W      = 64;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int SB_W       = 4;   // applied set bits, 0..7
	localparam int NW_W       = 5;   // applied way count, 1..15
	localparam int SHIFT_W    = 7;   // set bits plus offset bits
	localparam int WAY_IDX_W  = 4;   // way index, up to sixteen ways
	localparam int OUTCOME_W  = 2;
	localparam int WAY_OUT_W  = 3;

	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

	// configuration reset values
	localparam logic [2:0] SET_BITS_RST    = 3'd4;
	localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
	localparam logic [5:0] OFFSET_BITS_RST = 6'd4;

	// access outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// lookup result handed from the way logic to the top level
	typedef struct packed {
		outcome_t               outcome;
		logic [WAY_IDX_W-1:0]   way;
	} lookup_res_t;

	// saturating counter step
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_SAT) ? v : v + CNT_W'(1);
	endfunction

endpackage

FILE: design/salc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/salc_lookup.sv
// way compare, replacement choice and recency update for one set row
module salc_lookup #(
	parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
	localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int EW = 1 + salc_pkg::TAG_W + RW,
	localparam int ROW_W = MAX_WAYS * EW
) (
	input  logic [ROW_W-1:0]             row,
	input  logic [salc_pkg::TAG_W-1:0]   tag,
	input  logic [salc_pkg::NW_W-1:0]    nw,
	output logic [ROW_W-1:0]             new_row,
	output salc_pkg::lookup_res_t        res
);
	import salc_pkg::*;

	logic [MAX_WAYS-1:0] vld;
	logic [MAX_WAYS-1:0] use_w;
	logic [MAX_WAYS-1:0] match;
	logic [TAG_W-1:0]    tg [MAX_WAYS];
	logic [RW-1:0]       rc [MAX_WAYS];

	logic          hit_f, cold_f, vic_f;
	logic [RW-1:0] hit_w, cold_w, vic_w, vic_age;
	logic [RW-1:0] way_sel;
	logic [RW-1:0] old_rec;
	logic          fill;
	outcome_t      outc;

	// unpack the row into per-way fields
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w]   = row[w*EW + EW - 1];
			tg[w]    = row[w*EW + RW +: TAG_W];
			rc[w]    = row[w*EW +: RW];
			use_w[w] = NW_W'(w) < nw;
			match[w] = tg[w] == tag;
		end
	end

	// hit search, last invalid way, oldest valid way
	always_comb begin
		hit_f   = 1'b0;
		hit_w   = '0;
		cold_f  = 1'b0;
		cold_w  = '0;
		vic_f   = 1'b0;
		vic_w   = '0;
		vic_age = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (use_w[w]) begin
				if (!vld[w]) begin
					cold_f = 1'b1;
					cold_w = RW'(w);
				end else if (match[w]) begin
					if (!hit_f) begin
						hit_f = 1'b1;
						hit_w = RW'(w);
					end
				end else if (!vic_f || rc[w] > vic_age) begin
					vic_f   = 1'b1;
					vic_w   = RW'(w);
					vic_age = rc[w];
				end
			end
		end
	end

	// pick the way and outcome
	always_comb begin
		if (hit_f) begin
			way_sel = hit_w;
			outc    = OUT_HIT;
		end else if (cold_f) begin
			way_sel = cold_w;
			outc    = OUT_FILL;
		end else begin
			way_sel = vic_w;
			outc    = OUT_EVICT;
		end
		fill    = !hit_f && cold_f;
		old_rec = rc[way_sel];
		res.outcome = outc;
		res.way     = WAY_IDX_W'(way_sel);
	end

	// rebuild the row: chosen way becomes newest, younger ways (all valid ways on a fill) age by one
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (RW'(w) == way_sel) begin
				new_row[w*EW +: EW] = {1'b1, tag, RW'(0)};
			end else if (use_w[w] && vld[w] && (fill || rc[w] < old_rec) &&
					rc[w] < RW'(MAX_WAYS - 1)) begin
				new_row[w*EW +: EW] = {vld[w], tg[w], rc[w] + RW'(1)};
			end else begin
				new_row[w*EW +: EW] = {vld[w], tg[w], rc[w]};
			end
		end
	end

endmodule

FILE: design/set_assoc_lru_cache_tag_model_unit.sv
// top level of the set-associative lru cache tag model
// a transaction accepted at one edge is registered into busy_s1 with its row read, then its result is registered
// busy holds off a new transaction until the previous one has read and written back its set row
// the row ram has one read and one write port; no two transactions touch it at the same time
// reset: config returns to defaults, counters clear, then a clearing pass over all 2^MAX_SET_BITS
// rows (64 by default) zeroes the row ram with busy high; config writes are taken meanwhile
module set_assoc_lru_cache_tag_model_unit #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [salc_pkg::ADDR_W-1:0]       address,
	output logic                              done,
	output logic [salc_pkg::OUTCOME_W-1:0]    outcome,
	output logic [salc_pkg::WAY_OUT_W-1:0]    way_used,
	output logic [salc_pkg::CNT_W-1:0]        hit_total,
	output logic [salc_pkg::CNT_W-1:0]        miss_total,
	output logic [salc_pkg::CNT_W-1:0]        eviction_total
);
	import salc_pkg::*;

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int DEPTH = 1 << MAX_SET_BITS;
	localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int EW    = 1 + TAG_W + RW;
	localparam int ROW_W = MAX_WAYS * EW;

	// configuration registers
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] offset_q;

	// control state
	logic             clearing_q;
	logic [SET_W-1:0] clr_idx_q;
	logic             busy_s1;
	logic             done_q;
	logic [CNT_W-1:0] hits_q, misses_q, evicts_q;

	// payload registers
	logic [TAG_W-1:0]     tag_s1;
	logic [SET_W-1:0]     set_s1;
	logic [OUTCOME_W-1:0] outcome_q;
	logic [WAY_OUT_W-1:0] way_q;

	// address split
	logic [SB_W-1:0]    sb_eff;
	logic [NW_W-1:0]    nw_eff;
	logic [SHIFT_W-1:0] tshift;
	logic [ADDR_W-1:0]  addr_sh;
	logic [SET_W:0]     set_mask;
	logic [SET_W-1:0]   set_idx;
	logic [TAG_W-1:0]   tag_in;
	logic               acc;

	// ram and lookup
	logic               ram_we;
	logic [SET_W-1:0]   ram_waddr;
	logic [ROW_W-1:0]   ram_wdata;
	logic [ROW_W-1:0]   ram_rdata;
	logic [ROW_W-1:0]   new_row;
	lookup_res_t        res;

	assign acc = start && !busy;

	// applied config with clamping
	always_comb begin
		if ({1'b0, set_bits_q} > SB_W'(MAX_SET_BITS)) begin
			sb_eff = SB_W'(MAX_SET_BITS);
		end else begin
			sb_eff = {1'b0, set_bits_q};
		end
		if (ways_q == 4'd0) begin
			nw_eff = NW_W'(1);
		end else if ({1'b0, ways_q} > NW_W'(MAX_WAYS)) begin
			nw_eff = NW_W'(MAX_WAYS);
		end else begin
			nw_eff = {1'b0, ways_q};
		end
	end

	// set index and tag from the address
	always_comb begin
		tshift   = SHIFT_W'(sb_eff) + SHIFT_W'(offset_q);
		addr_sh  = address >> offset_q;
		set_mask = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
		set_idx  = addr_sh[SET_W-1:0] & set_mask[SET_W-1:0];
		tag_in   = (tshift >= SHIFT_W'(64)) ? '0 : address >> tshift;
	end

	// write port: clearing pass or row write-back
	always_comb begin
		ram_we    = clearing_q || busy_s1;
		ram_waddr = clearing_q ? clr_idx_q : set_s1;
		ram_wdata = clearing_q ? '0 : new_row;
	end

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (set_idx),
		.rdata (ram_rdata)
	);

	salc_lookup #(
		.MAX_WAYS (MAX_WAYS)
	) u_lookup (
		.row     (ram_rdata),
		.tag     (tag_s1),
		.nw      (nw_eff),
		.new_row (new_row),
		.res     (res)
	);

	// control, config and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SET_BITS_RST;
			ways_q     <= WAYS_IN_USE_RST;
			offset_q   <= OFFSET_BITS_RST;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			busy_s1    <= 1'b0;
			done_q     <= 1'b0;
			hits_q     <= '0;
			misses_q   <= '0;
			evicts_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SET_BITS:    set_bits_q <= cfg_wdata[2:0];
					CFG_WAYS_IN_USE: ways_q     <= cfg_wdata[3:0];
					CFG_OFFSET_BITS: offset_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + SET_W'(1);
				if (clr_idx_q == SET_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			busy_s1 <= acc;
			done_q  <= busy_s1;
			if (busy_s1) begin
				if (res.outcome == OUT_HIT) begin
					hits_q <= sat_inc(hits_q);
				end else begin
					misses_q <= sat_inc(misses_q);
				end
				if (res.outcome == OUT_EVICT) begin
					evicts_q <= sat_inc(evicts_q);
				end
			end
		end
	end

	// transaction payload and result fields
	always_ff @(posedge clk) begin
		if (acc) begin
			tag_s1 <= tag_in;
			set_s1 <= set_idx;
		end
		if (busy_s1) begin
			outcome_q <= res.outcome;
			way_q     <= WAY_OUT_W'(res.way);
		end
	end

	assign busy           = clearing_q || busy_s1;
	assign done           = done_q;
	assign outcome        = outcome_q;
	assign way_used       = way_q;
	assign hit_total      = hits_q;
	assign miss_total     = misses_q;
	assign eviction_total = evicts_q;

endmodule

FILE: design/salc_checker.sv
// port-level checks for the cache tag model, bound to the top level
module salc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [salc_pkg::OUTCOME_W-1:0] outcome,
	input logic [salc_pkg::CNT_W-1:0]     hit_total,
	input logic [salc_pkg::CNT_W-1:0]     miss_total
);
	import salc_pkg::*;

	// an accepted transaction is followed by its done result
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after accept");

	// results never come in consecutive cycles
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	// outcome never carries the unused code
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outcome == OUT_HIT || outcome == OUT_FILL || outcome == OUT_EVICT))
		else $error("unused outcome code");

	// a hit moves the hit total unless saturated, and leaves the miss total
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome == OUT_HIT) |->
			((hit_total != $past(hit_total) || hit_total == CNT_SAT) &&
			 miss_total == $past(miss_total)))
		else $error("hit total not updated on hit");

	// a miss moves the miss total unless saturated, and leaves the hit total
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome != OUT_HIT) |->
			((miss_total != $past(miss_total) || miss_total == CNT_SAT) &&
			 hit_total == $past(hit_total)))
		else $error("miss total not updated on miss");

endmodule

bind set_assoc_lru_cache_tag_model_unit salc_checker u_salc_checker (.*);
